// ----- hw/rtl/d2ba_pkg.sv -----
`timescale 1ns / 1ps
package d2ba_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_LONG    = 48;
   localparam int DIV_SHORT   = 32;

   localparam logic [31:0] HALF_TURN_DEG = 32'h00B4_0000;
   localparam logic [31:0] HALF_TURN_ANG = 32'h8000_0000;
   localparam logic [31:0] MOST_NEG      = 32'h8000_0000;
   localparam logic [31:0] SAT_POS       = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG       = 32'h8000_0000;
   localparam logic [31:0] DIV_SAT_LIMIT = HALF_TURN_DEG >> 14;
   localparam logic [7:0]  DEG_PER_HALF  = 8'd180;
   localparam logic [6:0]  WRAP_FACTOR   = 7'h77;
   localparam logic [31:0] SMALL_LIMIT   = 32'd1024;

   typedef enum logic [1:0] {
      CLS_ZERO,
      CLS_ERR,
      CLS_UNIT,
      CLS_DIVU
   } cls_type;

   // value is the half-turn unit, or the divisor for the unit when cls is CLS_DIVU
   typedef struct packed {
      cls_type     cls;
      logic [31:0] degrees;
      logic [31:0] value;
   } item_type;

   typedef struct packed {
      logic        start;
      logic        wide;
      logic [47:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [47:0] quotient;
      logic [31:0] remainder;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UDIV,
      ST_CHK,
      ST_L0,
      ST_LVL,
      ST_FIN,
      ST_LB,
      ST_WRAP,
      ST_QD,
      ST_PUSH
   } state_type;

endpackage

// ----- hw/rtl/d2ba_if.sv -----
`timescale 1ns / 1ps
interface d2ba_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] degrees;
   logic signed [31:0] scale;
   modport source(output valid, degrees, scale, input ready);
   modport sink(input valid, degrees, scale, output ready);
endinterface

interface d2ba_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] angle;
   logic        scale_error;
   modport source(output valid, angle, scale_error, input ready);
   modport sink(input valid, angle, scale_error, output ready);
endinterface

// ----- hw/rtl/degrees_to_binary_angle_core.sv -----
`timescale 1ns / 1ps
// Degrees to binary angle converter.
// req_bus carries one beat per conversion: degrees and scale, both signed 16.16.
// rsp_bus returns one beat per request, in order: a 32-bit binary angle
// (0x80000000 is a half turn) and scale_error, set when the scaled half-turn
// unit is zero or negative.
// A front stage classifies each request and writes it into a two-entry queue;
// the back end works one item at a time with a shared bit-serial divider
// (one quotient bit per cycle, 32 or 48 steps a run) and a halving loop that
// settles one level per cycle.
// Zero input and scale errors skip the divider; the common case takes one
// divider run and the halving loop, a negative scale can need a divide for
// the unit first, and an angle that wraps to zero needs one or two more
// divider runs. The back end sets the throughput.
// Reset empties the queue and the result register; no result is pending.
// When the receiver stalls, the finished result holds on rsp_bus, the back end
// finishes its current item and then waits; requests are taken until the queue
// is full.
module degrees_to_binary_angle_core (
   input logic        clock,
   input logic        reset,
   d2ba_req_if.sink   req_bus,
   d2ba_rsp_if.source rsp_bus
);

   logic                  push;
   logic                  space;
   logic                  head_valid;
   logic                  pop;
   d2ba_pkg::item_type    push_item;
   d2ba_pkg::item_type    head_item;
   d2ba_pkg::div_req_type div_req;
   d2ba_pkg::div_rsp_type div_rsp;

   d2ba_front u_front (
      .req_bus   (req_bus),
      .space     (space),
      .push      (push),
      .push_item (push_item)
   );

   d2ba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .space      (space),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   d2ba_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   d2ba_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ----- hw/rtl/d2ba_front.sv -----
`timescale 1ns / 1ps
module d2ba_front (
   d2ba_req_if.sink          req_bus,
   input  logic              space,
   output logic              push,
   output d2ba_pkg::item_type push_item
);

   logic [31:0] deg;
   logic [31:0] scl;
   logic [31:0] neg_scl;
   logic [39:0] prod;
   logic [31:0] unit_mul;

   assign deg      = req_bus.degrees;
   assign scl      = req_bus.scale;
   assign neg_scl  = 32'd0 - scl;
   assign prod     = scl * d2ba_pkg::DEG_PER_HALF;
   assign unit_mul = prod[31:0];

   assign req_bus.ready = space;
   assign push          = req_bus.valid & space;

   always_comb begin
      push_item.degrees = deg;
      push_item.value   = d2ba_pkg::HALF_TURN_DEG;
      push_item.cls     = d2ba_pkg::CLS_UNIT;
      if (deg == 32'd0 || deg == d2ba_pkg::MOST_NEG) begin
         push_item.cls = d2ba_pkg::CLS_ZERO;
      end else if (scl == 32'd0) begin
         push_item.cls = d2ba_pkg::CLS_UNIT;
      end else if (!scl[31]) begin
         push_item.value = unit_mul;
         if (unit_mul == 32'd0 || unit_mul[31]) push_item.cls = d2ba_pkg::CLS_ERR;
      end else if (neg_scl[31]) begin
         push_item.cls = d2ba_pkg::CLS_ERR;
      end else if (neg_scl <= d2ba_pkg::DIV_SAT_LIMIT) begin
         push_item.value = d2ba_pkg::SAT_POS;
      end else begin
         push_item.cls   = d2ba_pkg::CLS_DIVU;
         push_item.value = neg_scl;
      end
   end

endmodule

// ----- hw/rtl/d2ba_queue.sv -----
`timescale 1ns / 1ps
module d2ba_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  d2ba_pkg::item_type push_item,
   output logic               space,
   output logic               head_valid,
   output d2ba_pkg::item_type head_item,
   input  logic               pop
);

   localparam int PW = (d2ba_pkg::QUEUE_DEPTH > 1) ? $clog2(d2ba_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(d2ba_pkg::QUEUE_DEPTH + 1);

   d2ba_pkg::item_type store_ff [d2ba_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_pop;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      bump = (p == PW'(d2ba_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign space      = cnt_ff != CW'(d2ba_pkg::QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_item  = store_ff[rd_ff];
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_in  = push ? bump(wr_ff) : wr_ff;
      rd_in  = do_pop ? bump(rd_ff) : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) store_ff[wr_ff] <= push_item;
   end

endmodule

// ----- hw/rtl/d2ba_div.sv -----
`timescale 1ns / 1ps
module d2ba_div (
   input  logic                  clock,
   input  logic                  reset,
   input  d2ba_pkg::div_req_type req,
   output d2ba_pkg::div_rsp_type rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [32:0] trial;
   logic [32:0] diff;
   logic        ge;

   assign trial = {rem_ff, quo_ff[47]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = trial >= {1'b0, dsr_ff};

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         dsr_in  = req.divisor;
         quo_in  = req.wide ? req.dividend : {req.dividend[31:0], 16'h0};
         cnt_in  = req.wide ? 6'(d2ba_pkg::DIV_LONG) : 6'(d2ba_pkg::DIV_SHORT);
      end else if (busy_ff) begin
         rem_in = ge ? diff[31:0] : trial[31:0];
         quo_in = {quo_ff[46:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

endmodule

// ----- hw/rtl/d2ba_back.sv -----
`timescale 1ns / 1ps
module d2ba_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  d2ba_pkg::item_type    head_item,
   output logic                  pop,
   output d2ba_pkg::div_req_type div_req,
   input  d2ba_pkg::div_rsp_type div_rsp,
   d2ba_rsp_if.source            rsp_bus
);

   d2ba_pkg::state_type state_ff, state_in;
   logic [31:0] deg_ff, deg_in;
   logic [31:0] fa_ff, fa_in;
   logic [31:0] unit_ff, unit_in;
   logic [31:0] w_ff, w_in;
   logic [31:0] wa_ff, wa_in;
   logic [31:0] ra_ff, ra_in;
   logic [15:0] lo_ff, lo_in;
   logic [31:0] res_angle_ff, res_angle_in;
   logic        res_err_ff, res_err_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] angle_ff, angle_in;
   logic        err_ff, err_in;

   logic [31:0] deg_abs;
   logic [31:0] u2;
   logic [31:0] mu2;
   logic        sign_diff;
   logic [32:0] w2;
   logic [31:0] lb;
   logic [31:0] qd;
   logic signed [23:0] wp;

   function automatic logic [31:0] small_fold(input logic [31:0] q);
      logic [31:0] r;
      r          = {{9{q[31]}}, q[31:9]};
      small_fold = (r > d2ba_pkg::SMALL_LIMIT) ? 32'd0 - r : r;
   endfunction

   assign deg_abs   = deg_ff[31] ? 32'd0 - deg_ff : deg_ff;
   assign u2        = {unit_ff[30:0], 1'b0};
   assign mu2       = u2[31] ? 32'd0 - u2 : u2;
   assign sign_diff = deg_ff[31] ^ u2[31];
   assign w2        = {w_ff, 1'b0};
   assign lb        = deg_ff[31] ? 32'd0 - div_rsp.remainder : div_rsp.remainder;
   assign qd        = sign_diff ? 32'd0 - div_rsp.quotient[31:0] : div_rsp.quotient[31:0];
   assign wp        = $signed(lo_ff) * $signed({1'b0, d2ba_pkg::WRAP_FACTOR});

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.angle       = angle_ff;
   assign rsp_bus.scale_error = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= d2ba_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      deg_ff       <= deg_in;
      fa_ff        <= fa_in;
      unit_ff      <= unit_in;
      w_ff         <= w_in;
      wa_ff        <= wa_in;
      ra_ff        <= ra_in;
      lo_ff        <= lo_in;
      res_angle_ff <= res_angle_in;
      res_err_ff   <= res_err_in;
      angle_ff     <= angle_in;
      err_ff       <= err_in;
   end

   always_comb begin
      state_in     = state_ff;
      deg_in       = deg_ff;
      fa_in        = fa_ff;
      unit_in      = unit_ff;
      w_in         = w_ff;
      wa_in        = wa_ff;
      ra_in        = ra_ff;
      lo_in        = lo_ff;
      res_angle_in = res_angle_ff;
      res_err_in   = res_err_ff;
      angle_in     = angle_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      pop          = 1'b0;
      div_req      = '0;

      unique case (state_ff)
         d2ba_pkg::ST_IDLE: begin
            if (head_valid) begin
               pop          = 1'b1;
               deg_in       = head_item.degrees;
               unit_in      = head_item.value;
               res_angle_in = '0;
               res_err_in   = 1'b0;
               unique case (head_item.cls)
                  d2ba_pkg::CLS_ZERO: state_in = d2ba_pkg::ST_PUSH;
                  d2ba_pkg::CLS_ERR: begin
                     res_err_in = 1'b1;
                     state_in   = d2ba_pkg::ST_PUSH;
                  end
                  d2ba_pkg::CLS_UNIT: state_in = d2ba_pkg::ST_CHK;
                  d2ba_pkg::CLS_DIVU: begin
                     div_req.start    = 1'b1;
                     div_req.wide     = 1'b1;
                     div_req.dividend = {d2ba_pkg::HALF_TURN_DEG, 16'h0};
                     div_req.divisor  = head_item.value;
                     state_in         = d2ba_pkg::ST_UDIV;
                  end
                  default: state_in = d2ba_pkg::ST_IDLE;
               endcase
            end
         end
         d2ba_pkg::ST_UDIV: begin
            if (div_rsp.done) begin
               unit_in  = div_rsp.quotient[31:0];
               state_in = d2ba_pkg::ST_CHK;
            end
         end
         d2ba_pkg::ST_CHK: begin
            if (unit_ff == 32'd0 || unit_ff[31]) begin
               res_err_in = 1'b1;
               state_in   = d2ba_pkg::ST_PUSH;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {16'h0, deg_abs};
               div_req.divisor  = unit_ff;
               state_in         = d2ba_pkg::ST_L0;
            end
         end
         d2ba_pkg::ST_L0: begin
            if (div_rsp.done) begin
               ra_in    = {div_rsp.quotient[0], 31'h0};
               fa_in    = div_rsp.remainder;
               w_in     = unit_ff >> 1;
               wa_in    = d2ba_pkg::HALF_TURN_ANG >> 1;
               state_in = d2ba_pkg::ST_LVL;
            end
         end
         d2ba_pkg::ST_LVL: begin
            if (w_ff == 32'd0) begin
               state_in = d2ba_pkg::ST_FIN;
            end else begin
               if ({1'b0, fa_ff} >= w2) begin
                  fa_in = fa_ff - w2[31:0];
                  ra_in = ra_ff + {wa_ff[30:0], 1'b0};
               end else if (fa_ff >= w_ff) begin
                  fa_in = fa_ff - w_ff;
                  ra_in = ra_ff + wa_ff;
               end
               w_in  = w_ff >> 1;
               wa_in = wa_ff >> 1;
            end
         end
         d2ba_pkg::ST_FIN: begin
            if (ra_ff != 32'd0) begin
               res_angle_in = deg_ff[31] ? 32'd0 - ra_ff : ra_ff;
               state_in     = d2ba_pkg::ST_PUSH;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {16'h0, deg_abs};
               div_req.divisor  = mu2;
               state_in         = d2ba_pkg::ST_LB;
            end
         end
         d2ba_pkg::ST_LB: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder != 32'd0) begin
                  lo_in    = u2[15:0] - lb[15:0];
                  state_in = d2ba_pkg::ST_WRAP;
               end else if ((deg_abs >> 14) >= mu2) begin
                  res_angle_in = small_fold(sign_diff ? d2ba_pkg::SAT_NEG : d2ba_pkg::SAT_POS);
                  state_in     = d2ba_pkg::ST_PUSH;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.wide     = 1'b1;
                  div_req.dividend = {deg_abs, 16'h0};
                  div_req.divisor  = mu2;
                  state_in         = d2ba_pkg::ST_QD;
               end
            end
         end
         d2ba_pkg::ST_WRAP: begin
            res_angle_in = 32'd0 - {{8{wp[23]}}, wp};
            state_in     = d2ba_pkg::ST_PUSH;
         end
         d2ba_pkg::ST_QD: begin
            if (div_rsp.done) begin
               res_angle_in = small_fold(qd);
               state_in     = d2ba_pkg::ST_PUSH;
            end
         end
         d2ba_pkg::ST_PUSH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               angle_in     = res_angle_ff;
               err_in       = res_err_ff;
               state_in     = d2ba_pkg::ST_IDLE;
            end
         end
         default: state_in = d2ba_pkg::ST_IDLE;
      endcase
   end

endmodule

// ----- dv/d2ba_angle_board.sv -----
`timescale 1ns / 1ps
class d2ba_angle_board;
   logic [31:0] exp_angle[$];
   logic        exp_err[$];
   int          errors;

   static function logic [31:0] mag(logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   static function logic [31:0] fx_mul(logic [31:0] a, logic [31:0] b);
      logic signed [63:0] p;
      p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
      return p[47:16];
   endfunction

   static function logic [31:0] fx_div(logic [31:0] a, logic [31:0] b);
      logic signed [63:0] q;
      if ((mag(a) >> 14) >= mag(b))
         return (a[31] ^ b[31]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      q = ($signed({{32{a[31]}}, a}) * 64'sd65536) / $signed({{32{b[31]}}, b});
      return q[31:0];
   endfunction

   static function void convert(input logic [31:0] deg, input logic [31:0] scl,
                                output logic [31:0] ang, output logic err);
      logic [31:0] unit, w, wa, fa, ra, u2, mu2, lb, lo, r, q;
      ang = 0;
      err = 0;
      if (deg == 0 || deg == 32'h8000_0000) return;
      if (scl == 0) unit = 32'h00B4_0000;
      else if (!scl[31]) unit = fx_mul(32'h00B4_0000, scl);
      else unit = fx_div(32'h00B4_0000, 32'd0 - scl);
      if (unit == 0 || unit[31]) begin
         err = 1;
         return;
      end
      fa = mag(deg);
      w = unit;
      wa = 32'h8000_0000;
      ra = 0;
      while (fa != 0) begin
         while (fa < w) begin
            wa = wa >> 1;
            w = w >> 1;
         end
         if (w == 0) break;
         q = fa / w;
         ra = ra + q * wa;
         fa = fa - q * w;
      end
      if (ra != 0) begin
         ang = deg[31] ? (32'd0 - ra) : ra;
         return;
      end
      u2 = unit * 2;
      mu2 = mag(u2);
      lb = (mu2 != 0) ? (mag(deg) % mu2) : 0;
      if (deg[31]) lb = 32'd0 - lb;
      lo = u2 - lb;
      if (lb == 0) begin
         r = fx_mul(32'd128, fx_div(deg, u2));
         ang = (r > 32'd1024) ? (32'd0 - r) : r;
      end else begin
         r = fx_mul(lo << 16, 32'h77);
         ang = 32'd0 - r;
      end
   endfunction

   function void note_request(logic [31:0] deg, logic [31:0] scl);
      logic [31:0] a;
      logic e;
      convert(deg, scl, a, e);
      exp_angle.push_back(a);
      exp_err.push_back(e);
   endfunction

   function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endfunction

   function void check_result(logic [31:0] ang, logic err);
      logic [31:0] a;
      logic e;
      if (exp_angle.size() == 0) begin
         report($sformatf("unexpected beat angle=%h err=%b", ang, err));
         return;
      end
      a = exp_angle.pop_front();
      e = exp_err.pop_front();
      if (ang !== a) report($sformatf("angle %h, wanted %h", ang, a));
      if (err !== e) report($sformatf("scale_error %b, wanted %b", err, e));
   endfunction
endclass

// ----- dv/degrees_to_binary_angle_core_tb.sv -----
`timescale 1ns / 1ps
module degrees_to_binary_angle_core_tb;
   logic clock = 0;
   logic reset = 1;
   d2ba_req_if req_bus();
   d2ba_rsp_if rsp_bus();
   d2ba_angle_board board = new();
   int n_sent, n_recv, n_err;
   bit hold_off, all_sent;

   degrees_to_binary_angle_core dut (.clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus));

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_bus.valid = 0;
      req_bus.degrees = 0;
      req_bus.scale = 0;
      rsp_bus.ready = 0;
   end

   function int gap_len();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
      return $urandom_range(0, 4);
   endfunction

   function logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 32'h00FF_FFFF);
         2: return 32'd0 - $urandom_range(0, 32'h00FF_FFFF);
         3: return $urandom_range(0, 300) << 16;
         4: return $urandom_range(0, 64);
         default: return 32'd0 - ($urandom_range(0, 300) << 16);
      endcase
   endfunction

   task send(input logic [31:0] deg, input logic [31:0] scl);
      req_bus.valid <= 1;
      req_bus.degrees <= deg;
      req_bus.scale <= scl;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(deg, scl);
      n_sent++;
   endtask

   task idle(input int n);
      if (n == 0) return;
      req_bus.valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      logic [31:0] dv[$];
      logic [31:0] sv[$];
      dv = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001, 32'h00B4_0000,
             32'hFF4C_0000, 32'h0168_0000, 32'h0001_0000, 32'd1, 32'hFFFF_FFFF,
             32'h0168_0000, 32'h02D0_0000, 32'h005A_0000, 32'h0168_0000};
      sv = '{32'h0001_0000, 32'h0002_0000, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000,
             32'd1, 32'hFFFF_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h0100_0000,
             32'd0, 32'd0, 32'hFFFF_FFFF, 32'h0000_0001};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (dv[i]) send(dv[i], sv[i]);
      for (int i = 0; i < 8; i++) send($urandom(), sv[i]);
      idle(1);
      hold_off = 1;
      for (int i = 0; i < 1150; i++) begin
         if (i == 300) hold_off = 1;
         send(rand_field(), ($urandom_range(0, 3) == 0) ? 32'd0 : rand_field());
         idle(gap_len());
      end
      req_bus.valid <= 0;
      all_sent = 1;
   end

   // receiver, with a long hold-off on request
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_bus.ready <= 0;
            hold_off = 0;
            repeat (600) @(posedge clock);
         end
         if ($urandom_range(0, 49) == 0) begin
            rsp_bus.ready <= 0;
            repeat ($urandom_range(20, 150)) @(posedge clock);
            rsp_bus.ready <= 1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 1) == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_result(rsp_bus.angle, rsp_bus.scale_error);
         n_recv++;
         if (rsp_bus.scale_error) n_err++;
      end
   end

   initial begin
      wait (all_sent);
      while (board.exp_angle.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d conversions, %0d with scale error, two long stalls",
               n_recv, n_err);
      if (board.errors == 0 && board.exp_angle.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule
